// ===== hdl/ppsc_pkg.sv =====
// Shared types, codes and character helpers for the password policy checker.
package ppsc_pkg;

  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned LEN_BITS       = 8;
  localparam int unsigned OUT_DATA_BITS  = 16;
  localparam logic [7:0]  RUN_MIN        = 8'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIN_LENGTH      = 3'd0,
    CFG_REQUIRED_CATS   = 3'd1,
    CFG_SEQUENCE_ENABLE = 3'd2,
    CFG_SEQUENCE_LENGTH = 3'd3,
    CFG_REPEAT_ENABLE   = 3'd4,
    CFG_REPEAT_LENGTH   = 3'd5
  } cfg_index_e;

  typedef enum logic [2:0] {
    REJ_NONE       = 3'd0,
    REJ_LENGTH     = 3'd1,
    REJ_COMPLEXITY = 3'd2,
    REJ_SEQUENCE   = 3'd3,
    REJ_REPEAT     = 3'd4
  } reject_code_e;

  // Per-password status after the current character has been folded in.
  typedef struct packed {
    logic [LEN_BITS-1:0] length;   // clipped to 255
    logic [3:0]          cats;     // bit0 upper, bit1 lower, bit2 digit, bit3 special
    logic                seq_hit;
    logic                rep_hit;
  } track_status_t;

  function automatic logic is_upper(logic [31:0] c);
    return (c >= 32'h41) && (c <= 32'h5A);
  endfunction

  function automatic logic [3:0] category_of(logic [31:0] c);
    logic [3:0] cat;
    cat = 4'b0000;
    if (is_upper(c)) begin
      cat = 4'b0001;
    end else if (c >= 32'h61 && c <= 32'h7A) begin
      cat = 4'b0010;
    end else if (c >= 32'h30 && c <= 32'h39) begin
      cat = 4'b0100;
    end else if ((c >= 32'h21 && c <= 32'h2F) || (c >= 32'h3A && c <= 32'h40) ||
                 (c >= 32'h5B && c <= 32'h60) || (c >= 32'h7B && c <= 32'h7E) ||
                 (c >= 32'h09 && c <= 32'h0D) || (c == 32'h20)) begin
      cat = 4'b1000;
    end
    return cat;
  endfunction

endpackage

// ===== hdl/ppsc_tracker.sv =====
// Per-password run, category and length tracking.
module ppsc_tracker
  import ppsc_pkg::*;
#(
  parameter int unsigned SYMBOL_BITS = 16,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,   // stage holds a character that moves on
  input  logic [SYMBOL_BITS-1:0] symbol_i,
  input  logic                   last_i,
  input  logic [7:0]             seq_len_i,
  input  logic [7:0]             rep_len_i,
  output track_status_t          status_o
);

  localparam int unsigned CmpBits = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam int unsigned ExtBits = SYMBOL_BITS + 1;

  logic [COUNT_BITS-1:0]  length_q, length_d;
  logic [3:0]             cats_q, cats_d;
  logic [SYMBOL_BITS-1:0] prior_q;
  logic                   prior_valid_q;
  logic [COUNT_BITS-1:0]  up_q, up_d, down_q, down_d, same_q, same_d;
  logic                   seq_hit_q, seq_hit_d, rep_hit_q, rep_hit_d;

  logic [SYMBOL_BITS-1:0] cur_fold, prev_fold;
  logic [ExtBits-1:0]     cur_ext, prev_ext;
  logic                   step_up, step_down, same;
  logic [CmpBits-1:0]     seq_thr, rep_thr, len_ext;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  always_comb begin
    cur_fold  = is_upper(32'(symbol_i)) ? symbol_i + SYMBOL_BITS'(8'h20) : symbol_i;
    prev_fold = is_upper(32'(prior_q))  ? prior_q  + SYMBOL_BITS'(8'h20) : prior_q;
    cur_ext   = ExtBits'(cur_fold);
    prev_ext  = ExtBits'(prev_fold);
    // no wrap: steps compared one bit wider
    step_up   = (cur_ext == prev_ext + 1'b1);
    step_down = (cur_ext + 1'b1 == prev_ext);
    same      = (symbol_i == prior_q);

    length_d = sat_inc(length_q);
    cats_d   = cats_q | category_of(32'(symbol_i));
    up_d     = (prior_valid_q && step_up)   ? sat_inc(up_q)   : '0;
    down_d   = (prior_valid_q && step_down) ? sat_inc(down_q) : '0;
    same_d   = (prior_valid_q && same)      ? sat_inc(same_q) : '0;

    seq_thr   = CmpBits'(seq_len_i - 8'd1);
    rep_thr   = CmpBits'(rep_len_i - 8'd1);
    seq_hit_d = seq_hit_q | ((seq_len_i >= RUN_MIN) &&
                             ((CmpBits'(up_d) >= seq_thr) || (CmpBits'(down_d) >= seq_thr)));
    rep_hit_d = rep_hit_q | ((rep_len_i >= RUN_MIN) && (CmpBits'(same_d) >= rep_thr));

    len_ext = CmpBits'(length_d);
    status_o.length  = (len_ext > CmpBits'(255)) ? 8'hFF : len_ext[LEN_BITS-1:0];
    status_o.cats    = cats_d;
    status_o.seq_hit = seq_hit_d;
    status_o.rep_hit = rep_hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q      <= '0;
      cats_q        <= '0;
      prior_q       <= '0;
      prior_valid_q <= 1'b0;
      up_q          <= '0;
      down_q        <= '0;
      same_q        <= '0;
      seq_hit_q     <= 1'b0;
      rep_hit_q     <= 1'b0;
    end else if (advance_i) begin
      if (last_i) begin
        length_q      <= '0;
        cats_q        <= '0;
        prior_q       <= '0;
        prior_valid_q <= 1'b0;
        up_q          <= '0;
        down_q        <= '0;
        same_q        <= '0;
        seq_hit_q     <= 1'b0;
        rep_hit_q     <= 1'b0;
      end else begin
        length_q      <= length_d;
        cats_q        <= cats_d;
        prior_q       <= symbol_i;
        prior_valid_q <= 1'b1;
        up_q          <= up_d;
        down_q        <= down_d;
        same_q        <= same_d;
        seq_hit_q     <= seq_hit_d;
        rep_hit_q     <= rep_hit_d;
      end
    end
  end

endmodule

// ===== hdl/password_policy_stream_checker.sv =====
// Top level of the streaming password policy checker.
//
//  channel   | dir | transaction                   | payload
//  ----------+-----+-------------------------------+-----------------------------------
//  s_axis    | in  | one password character        | tdata: symbol; tlast: final_symbol
//  m_axis    | out | one verdict per password      | tdata: accepted, reject_code, char_count
//  cfg       | in  | one policy register write     | cfg_index_i, cfg_data_i
//
//  One character per cycle sustained, except while a final character stalls (below).
//  A character is held in the input register; the verdict of a final character
//  lands in the output register, which drives m_axis.
//  Only the output register can stall: while a verdict waits, a final character
//  in the input register holds, and s_axis_tready drops behind it.
//  Reset clears the per-password state and loads the policy defaults
//  (min length 8, three categories, both run checks on with length 4).
module password_policy_stream_checker
  import ppsc_pkg::*;
#(
  parameter int unsigned SYMBOL_BITS = 16,
  parameter int unsigned COUNT_BITS  = 8,
  localparam int unsigned InDataBits = ((SYMBOL_BITS + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // character stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [InDataBits-1:0]       s_axis_tdata,   // [SYMBOL_BITS-1:0] symbol, rest zero
  input  logic                        s_axis_tlast,   // final_symbol
  // verdict stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]    m_axis_tdata,   // [0] accepted, [3:1] reject_code,
                                                      // [11:4] char_count, [15:12] zero
  // policy registers
  input  logic                        cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data_i
);

  // Policy registers
  logic [7:0] min_length_q, seq_len_q, rep_len_q;
  logic [2:0] req_cats_q;
  logic       seq_en_q, rep_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= 8'd8;
      req_cats_q   <= 3'd3;
      seq_en_q     <= 1'b1;
      seq_len_q    <= 8'd4;
      rep_en_q     <= 1'b1;
      rep_len_q    <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_LENGTH:      min_length_q <= cfg_data_i;
        CFG_REQUIRED_CATS:   req_cats_q   <= cfg_data_i[2:0];
        CFG_SEQUENCE_ENABLE: seq_en_q     <= cfg_data_i[0];
        CFG_SEQUENCE_LENGTH: seq_len_q    <= cfg_data_i;
        CFG_REPEAT_ENABLE:   rep_en_q     <= cfg_data_i[0];
        CFG_REPEAT_LENGTH:   rep_len_q    <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Input register
  logic                   in_valid_q;
  logic [SYMBOL_BITS-1:0] in_sym_q;
  logic                   in_last_q;
  logic                   advance;

  // a non-final character never needs the output register
  assign advance       = in_valid_q && (!in_last_q || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sym_q  <= s_axis_tdata[SYMBOL_BITS-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  track_status_t status;

  ppsc_tracker #(
    .SYMBOL_BITS(SYMBOL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_tracker (
    .clk_i,
    .rst_ni,
    .advance_i (advance),
    .symbol_i  (in_sym_q),
    .last_i    (in_last_q),
    .seq_len_i (seq_len_q),
    .rep_len_i (rep_len_q),
    .status_o  (status)
  );

  // Verdict, in priority order
  logic [2:0]   cat_total;
  reject_code_e code_d;

  always_comb begin
    cat_total = 3'(status.cats[0]) + 3'(status.cats[1]) +
                3'(status.cats[2]) + 3'(status.cats[3]);
    if (status.length < min_length_q) begin
      code_d = REJ_LENGTH;
    end else if (cat_total < req_cats_q) begin
      code_d = REJ_COMPLEXITY;
    end else if (seq_en_q && status.seq_hit) begin
      code_d = REJ_SEQUENCE;
    end else if (rep_en_q && status.rep_hit) begin
      code_d = REJ_REPEAT;
    end else begin
      code_d = REJ_NONE;
    end
  end

  // Output register
  logic                out_valid_q;
  reject_code_e        out_code_q;
  logic [LEN_BITS-1:0] out_len_q;
  logic                load_out;

  assign load_out = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_code_q <= code_d;
      out_len_q  <= status.length;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_len_q, out_code_q, out_code_q == REJ_NONE};

  // Checks
  a_new_verdict_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_last_q))
    else $error("verdict appeared without a final character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready))
    else $error("verdict overwritten before it was taken");

  a_pass_meets_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_code_q == REJ_NONE) |-> (out_len_q >= min_length_q))
    else $error("passing verdict below minimum length");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_code_q == REJ_NONE || out_code_q == REJ_LENGTH ||
                     out_code_q == REJ_COMPLEXITY || out_code_q == REJ_SEQUENCE ||
                     out_code_q == REJ_REPEAT))
    else $error("undefined reject code");

  a_stall_only_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q))
    else $error("input stalled without a waiting verdict");

endmodule
